[rtl/lms_sine_reference_canceller_defines.svh]
// Assertion macros for the LMS sine reference canceller.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef LMS_SINE_REFERENCE_CANCELLER_DEFINES_SVH
`define LMS_SINE_REFERENCE_CANCELLER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LSRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsrc: same-cycle check failed");
// next-cycle implication
`define LSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsrc: next-cycle check failed");
`else
`define LSRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/lsrc_pkg.sv]
// Shared constants, types and the quarter-wave sine generator for the canceller.
// No dependencies; all files but the defines header use it by scoped names.
package lsrc_pkg;

	localparam int SampleW    = 16;
	localparam int PhaseW     = 32;
	localparam int StepW      = 16;
	localparam int TapCntW    = 6;
	localparam int WeightFrac = 20;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 32;
	localparam int MuErrW     = StepW + 1 + SampleW;

	localparam logic [TapCntW-1:0] TapCountReset = 6'd16;

	localparam int TableEntries = 1024;
	localparam int TblIdxW      = $clog2(TableEntries);
	localparam int ScaledW      = TblIdxW + PhaseW - 1;
	localparam logic [TblIdxW-1:0] TblLast = TblIdxW'(TableEntries - 1);

	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
	localparam logic [63:0] TblDiv    = 64'(TableEntries - 1);

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_STEP_SIZE  = 2'd1,
		CFG_TAP_COUNT  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic load_item;
		logic start_pass;
		logic issue;
		logic upd_pass;
		logic calc_err;
		logic calc_mu;
		logic advance_phase;
	} lsrc_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} lsrc_status_t;

	// Quarter-wave entry in Q1.15: Taylor series in Q30 up to x^13, round, clamp.
	function automatic logic [SampleW-1:0] sine_entry(input logic [63:0] i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [63:0] s;
		x  = (i * HalfPiQ30) / TblDiv;
		x2 = (x * x) >> 30;
		t  = ((x * x2) >> 30) / 64'd6;
		s  = $signed(x) - $signed(t);
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + $signed(t);
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - $signed(t);
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + $signed(t);
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - $signed(t);
		t  = ((t * x2) >> 30) / 64'd156;
		s  = s + $signed(t);
		s  = (s + 64'sd16384) >>> 15;
		if (s < 64'sd0)
			s = 64'sd0;
		else if (s > 64'sd32767)
			s = 64'sd32767;
		return s[SampleW-1:0];
	endfunction

endpackage

[rtl/lsrc_if.sv]
// Valid/ready channel interfaces: sample input, result output, register writes.
// Widths come from lsrc_pkg.
interface lsrc_in_if;
	logic valid;
	logic ready;
	logic signed [lsrc_pkg::SampleW-1:0] sample_in;
	logic last_in_block;
	modport source(output valid, sample_in, last_in_block, input ready);
	modport sink(input valid, sample_in, last_in_block, output ready);
endinterface

interface lsrc_out_if;
	logic valid;
	logic ready;
	logic signed [lsrc_pkg::SampleW-1:0] error_out;
	logic last_out;
	modport source(output valid, error_out, last_out, input ready);
	modport sink(input valid, error_out, last_out, output ready);
endinterface

interface lsrc_cfg_if;
	logic valid;
	logic ready;
	logic [lsrc_pkg::CfgIdxW-1:0] index;
	logic [lsrc_pkg::CfgDataW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/lms_sine_reference_canceller.sv]
// LMS canceller for a known-frequency tone, driven by a sine reference.
// Channels: samples (sink) carries sample_in and last_in_block; results (source)
// carries error_out and last_out, one result per sample, in order; cfg (sink)
// writes phase_step (index 0), step_size (index 1) and tap_count (index 2),
// always ready, other indexes ignored. Write cfg only while the block is idle.
// Each sample runs an estimate pass and an update pass over the N taps in use
// (N = tap_count limited to MAX_TAPS), one tap per cycle through the single
// shared multiplier and the weight memory (one read and one write a cycle).
// The result is registered once the estimate pass has drained and the result
// register is free; the next sample is taken once the update pass has drained.
// The result sits in an output register: a stalled receiver holds it, and the
// update pass and the next sample proceed; only the following result waits.
// Reset: weights read as zero, phase 0, phase_step 0, step_size 0, tap_count 16.
// The sine table is constant and needs no fill time after reset.
// Uses lsrc_pkg, the lsrc_*_if interfaces, lsrc_ctrl and lsrc_datapath.
`include "lms_sine_reference_canceller_defines.svh"
module lms_sine_reference_canceller #(
	parameter int MAX_TAPS = 32,
	parameter int WEIGHT_WIDTH = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	lsrc_in_if.sink      samples,
	lsrc_out_if.source   results,
	lsrc_cfg_if.sink     cfg
);

	localparam int CntW = $clog2(MAX_TAPS + 1);
	localparam int TapW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [lsrc_pkg::PhaseW-1:0]  phase_step_q;
	logic [lsrc_pkg::StepW-1:0]   step_size_q;
	logic [lsrc_pkg::TapCntW-1:0] tap_count_q;
	logic [CntW-1:0]              n_taps;

	lsrc_pkg::lsrc_cmd_t    cmd;
	lsrc_pkg::lsrc_status_t status;
	logic [TapW-1:0]        tap_idx;
	logic                   in_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			step_size_q  <= '0;
			tap_count_q  <= lsrc_pkg::TapCountReset;
		end else if (cfg.valid) begin
			case (lsrc_pkg::cfg_reg_t'(cfg.index))
				lsrc_pkg::CFG_PHASE_STEP: phase_step_q <= cfg.data[lsrc_pkg::PhaseW-1:0];
				lsrc_pkg::CFG_STEP_SIZE:  step_size_q  <= cfg.data[lsrc_pkg::StepW-1:0];
				lsrc_pkg::CFG_TAP_COUNT:  tap_count_q  <= cfg.data[lsrc_pkg::TapCntW-1:0];
				default: begin
				end
			endcase
		end
	end

	// limit the tap count to the storage
	always_comb begin
		if (int'(tap_count_q) > MAX_TAPS)
			n_taps = CntW'(MAX_TAPS);
		else
			n_taps = CntW'(tap_count_q);
	end

	lsrc_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.n_taps   (n_taps),
		.status   (status),
		.cmd      (cmd),
		.tap_idx  (tap_idx)
	);

	assign samples.ready = in_ready;

	lsrc_datapath #(
		.MAX_TAPS     (MAX_TAPS),
		.WEIGHT_WIDTH (WEIGHT_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.tap_idx    (tap_idx),
		.sample_in  (samples.sample_in),
		.last_in    (samples.last_in_block),
		.phase_step (phase_step_q),
		.step_size  (step_size_q),
		.out_ready  (results.ready),
		.out_valid  (results.valid),
		.error_out  (results.error_out),
		.last_out   (results.last_out),
		.status     (status)
	);

	// a taken sample keeps the input closed for at least the next cycle
	`LSRC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, samples.valid && in_ready, !in_ready)
	// nothing in flight in the tap pipeline while waiting for a sample
	`LSRC_ASSERT_IMP(a_idle_pipe_empty, clk, arst_n, in_ready, !status.busy)
	// a new error never overwrites a result that is still pending
	`LSRC_ASSERT_IMP(a_no_result_overrun, clk, arst_n, cmd.calc_err, !results.valid || results.ready)

endmodule

[rtl/lsrc_ctrl.sv]
// Sequencer for the canceller: estimate pass, error, update pass, phase advance.
// Uses lsrc_pkg command/status types; drives lsrc_datapath.
module lsrc_ctrl #(
	parameter int MAX_TAPS = 32,
	localparam int CntW = $clog2(MAX_TAPS + 1),
	localparam int TapW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CntW-1:0]        n_taps,
	input  lsrc_pkg::lsrc_status_t status,
	output lsrc_pkg::lsrc_cmd_t    cmd,
	output logic [TapW-1:0]        tap_idx
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EST    = 7'b0000010,
		S_EDRAIN = 7'b0000100,
		S_ERR    = 7'b0001000,
		S_MUL    = 7'b0010000,
		S_UPD    = 7'b0100000,
		S_UDRAIN = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item  = 1'b1;
					cmd.start_pass = 1'b1;
					cnt_d          = '0;
					state_d        = S_EST;
				end
			end
			S_EST: begin
				if (cnt_q == n_taps) begin
					state_d = S_EDRAIN;
				end else begin
					cmd.issue = 1'b1;
					cnt_d     = cnt_q + 1'b1;
				end
			end
			S_EDRAIN: begin
				if (!status.busy)
					state_d = S_ERR;
			end
			S_ERR: begin
				// hold until the result register can take the new error
				if (status.out_free) begin
					cmd.calc_err = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.calc_mu    = 1'b1;
				cmd.start_pass = 1'b1;
				cnt_d          = '0;
				state_d        = S_UPD;
			end
			S_UPD: begin
				if (cnt_q == n_taps) begin
					state_d = S_UDRAIN;
				end else begin
					cmd.issue    = 1'b1;
					cmd.upd_pass = 1'b1;
					cnt_d        = cnt_q + 1'b1;
				end
			end
			S_UDRAIN: begin
				if (!status.busy) begin
					cmd.advance_phase = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign tap_idx  = cnt_q[TapW-1:0];

endmodule

[rtl/lsrc_sine_rom.sv]
// Quarter-wave sine ROM with registered read.
// Entries are built at elaboration by lsrc_pkg::sine_entry.
module lsrc_sine_rom (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [lsrc_pkg::TblIdxW-1:0]  addr,
	output logic [lsrc_pkg::SampleW-1:0]  data
);

	logic [lsrc_pkg::SampleW-1:0] tbl [lsrc_pkg::TableEntries];

	for (genvar g = 0; g < lsrc_pkg::TableEntries; g++) begin : g_tbl
		assign tbl[g] = lsrc_pkg::sine_entry(64'(g));
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			data <= tbl[addr];
	end

endmodule

[rtl/lsrc_datapath.sv]
// Datapath: phase walk, sine lookup, weight memory, shared multiplier, accumulator,
// error saturation, weight update and the result register. Uses lsrc_pkg, lsrc_sine_rom.
module lsrc_datapath #(
	parameter int MAX_TAPS = 32,
	parameter int WEIGHT_WIDTH = 24,
	localparam int TapW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lsrc_pkg::lsrc_cmd_t                   cmd,
	input  logic [TapW-1:0]                       tap_idx,
	input  logic signed [lsrc_pkg::SampleW-1:0]   sample_in,
	input  logic                                  last_in,
	input  logic [lsrc_pkg::PhaseW-1:0]           phase_step,
	input  logic [lsrc_pkg::StepW-1:0]            step_size,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [lsrc_pkg::SampleW-1:0]   error_out,
	output logic                                  last_out,
	output lsrc_pkg::lsrc_status_t                status
);

	localparam int SW      = lsrc_pkg::SampleW;
	localparam int PhW     = lsrc_pkg::PhaseW;
	localparam int WW      = WEIGHT_WIDTH;
	localparam int CntW    = $clog2(MAX_TAPS + 1);
	localparam int EstW    = WW + SW + CntW;
	localparam int SampShW = SW + lsrc_pkg::WeightFrac;
	localparam int DiffW   = ((EstW > SampShW) ? EstW : SampShW) + 1;
	localparam int ErrW    = DiffW - lsrc_pkg::WeightFrac;
	localparam int MulW    = (WW > lsrc_pkg::MuErrW) ? WW : lsrc_pkg::MuErrW;
	localparam int PW      = MulW + SW;
	// 2*mu*e*r: Q0.16 * Q.15 * Q.15 doubled, back to Q.20
	localparam int UpdShift = lsrc_pkg::StepW + 2 * (SW - 1) - lsrc_pkg::WeightFrac - 1;
	localparam int DW      = PW - UpdShift;
	localparam int SumW    = ((WW > DW) ? WW : DW) + 1;

	localparam logic signed [DiffW-1:0] HalfErr = DiffW'(64'd1 << (lsrc_pkg::WeightFrac - 1));
	localparam logic signed [PW-1:0]    HalfUpd = PW'(64'd1 << (UpdShift - 1));
	localparam logic [PhW-2:0]          QuarterTurn = (PhW - 1)'(1) << (PhW - 2);

	// item and phase registers
	logic signed [SW-1:0] sample_q;
	logic                 last_q;
	logic [PhW-1:0]       phase_acc_q;
	logic [PhW-1:0]       ph_q;

	// sine address from the current tap phase
	logic [1:0]                        quad;
	logic [PhW-2:0]                    fm;
	logic [lsrc_pkg::ScaledW-1:0]      scaled;
	logic [lsrc_pkg::TblIdxW:0]        idx_top;
	logic [lsrc_pkg::TblIdxW-1:0]      rom_addr;

	// stage 1
	logic                 v_s1, upd_s1, neg_s1, wv_s1;
	logic [TapW-1:0]      k_s1;
	logic signed [WW-1:0] wrd_s1;
	logic [SW-1:0]        sine_s1;
	logic signed [SW-1:0] refv;
	logic signed [WW-1:0] w_s1;
	logic signed [MulW-1:0] mul_a;
	logic signed [PW-1:0] prod_c;

	// stage 2
	logic                 v_s2, upd_s2;
	logic [TapW-1:0]      k_s2;
	logic signed [WW-1:0] w_s2;
	logic signed [PW-1:0] prod_s2;

	// weight memory
	logic signed [WW-1:0] wmem [MAX_TAPS];
	logic [MAX_TAPS-1:0]  wvalid_q;
	logic                 wr_en;
	logic signed [PW-1:0] upd_rnd;
	logic signed [DW-1:0] dlt;
	logic signed [SumW-1:0] wsum;
	logic                 w_ovf;
	logic signed [WW-1:0] w_new;

	// accumulator and error
	logic signed [EstW-1:0]   acc_q;
	logic signed [DiffW-1:0]  diff_c;
	logic signed [ErrW-1:0]   errw;
	logic                     e_ovf;
	logic signed [SW-1:0]     err_sat;
	logic signed [SW-1:0]     err_q;
	logic signed [lsrc_pkg::MuErrW-1:0] mu_err_q;

	logic                 out_valid_q;
	logic signed [SW-1:0] error_q;
	logic                 last_out_q;

	assign quad     = ph_q[PhW-1 -: 2];
	assign fm       = quad[0] ? (QuarterTurn - {1'b0, ph_q[PhW-3:0]}) : {1'b0, ph_q[PhW-3:0]};
	assign scaled   = lsrc_pkg::ScaledW'(fm) * lsrc_pkg::ScaledW'(lsrc_pkg::TblLast);
	assign idx_top  = scaled[lsrc_pkg::ScaledW-1 -: (lsrc_pkg::TblIdxW + 1)];
	assign rom_addr = (idx_top > {1'b0, lsrc_pkg::TblLast}) ? lsrc_pkg::TblLast
		: idx_top[lsrc_pkg::TblIdxW-1:0];

	lsrc_sine_rom u_rom (
		.clk   (clk),
		.rd_en (cmd.issue),
		.addr  (rom_addr),
		.data  (sine_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (cmd.advance_phase) begin
			phase_acc_q <= phase_acc_q + phase_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sample_q <= sample_in;
			last_q   <= last_in;
		end
		// walk back one phase step per tap
		if (cmd.start_pass)
			ph_q <= phase_acc_q;
		else if (cmd.issue)
			ph_q <= ph_q - phase_step;
	end

	// stage 1: table and weight reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			upd_s1 <= cmd.upd_pass;
			neg_s1 <= quad[1];
			k_s1   <= tap_idx;
			wrd_s1 <= wmem[tap_idx];
			wv_s1  <= wvalid_q[tap_idx];
		end
	end

	// stage 2: signed reference and one shared multiply
	assign refv   = neg_s1 ? -$signed(sine_s1) : $signed(sine_s1);
	assign w_s1   = wv_s1 ? wrd_s1 : '0;
	assign mul_a  = upd_s1 ? MulW'(mu_err_q) : MulW'(w_s1);
	assign prod_c = mul_a * refv;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			upd_s2  <= upd_s1;
			k_s2    <= k_s1;
			w_s2    <= w_s1;
			prod_s2 <= prod_c;
		end
	end

	// stage 3: accumulate or write back a saturated weight
	assign wr_en   = v_s2 & upd_s2;
	assign upd_rnd = prod_s2 + HalfUpd;
	assign dlt     = upd_rnd[PW-1:UpdShift];
	assign wsum    = SumW'(w_s2) + SumW'(dlt);
	assign w_ovf   = !((&wsum[SumW-1:WW-1]) || !(|wsum[SumW-1:WW-1]));
	assign w_new   = w_ovf ? (wsum[SumW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}})
		: wsum[WW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (wr_en) begin
			wvalid_q[k_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			wmem[k_s2] <= w_new;
	end

	always_ff @(posedge clk) begin
		if (cmd.start_pass)
			acc_q <= '0;
		else if (v_s2 && !upd_s2)
			acc_q <= acc_q + EstW'(prod_s2);
	end

	// error: round half up out of Q.20, saturate to Q1.15
	assign diff_c  = (DiffW'(sample_q) <<< lsrc_pkg::WeightFrac) - DiffW'(acc_q) + HalfErr;
	assign errw    = diff_c[DiffW-1:lsrc_pkg::WeightFrac];
	assign e_ovf   = !((&errw[ErrW-1:SW-1]) || !(|errw[ErrW-1:SW-1]));
	assign err_sat = e_ovf ? (errw[ErrW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
		: errw[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.calc_err)
			err_q <= err_sat;
		if (cmd.calc_mu)
			mu_err_q <= $signed({1'b0, step_size}) * err_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.calc_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_err) begin
			error_q    <= err_sat;
			last_out_q <= last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign error_out       = error_q;
	assign last_out        = last_out_q;
	assign status.busy     = v_s1 | v_s2;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for lms_sine_reference_canceller: a directed table, then random
// register settings with tone-plus-noise, full-scale and random samples, scored
// against an integer predictor. Depends on lsrc_pkg, lsrc_*_if and the canceller RTL.
module tb;

	localparam int NumTaps = 32;
	localparam int QsineLen = 1024;
	localparam int WeightBits = 24;
	localparam longint unsigned HalfPiQ30Val = 64'd1686629713;
	localparam longint CoefMax = (64'sd1 <<< (WeightBits - 1)) - 1;
	localparam longint CoefMin = -CoefMax - 1;
	localparam logic [lsrc_pkg::CfgIdxW-1:0] CfgUnmapped = 2'd3;
	localparam int SettleCycles = 100;
	localparam int HoldOffCycles = 400;
	localparam int WatchdogLimit = 5000;
	localparam int RandomItems = 2000;
	localparam int IdlePct = 22;

	typedef struct packed {
		logic signed [lsrc_pkg::SampleW-1:0] err;
		logic last;
	} result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [lsrc_pkg::CfgIdxW-1:0] idx;
		logic [lsrc_pkg::CfgDataW-1:0] data;
		logic signed [lsrc_pkg::SampleW-1:0] sample;
		logic last;
		logic known;
		logic signed [lsrc_pkg::SampleW-1:0] err;
	} dir_row_t;

	// known rows: reset state and zero taps pass the sample straight through
	localparam int DirLen = 31;
	localparam dir_row_t DirRows [DirLen] = '{
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh8000, 1'b1, 1'b1, 16'sh8000},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh0000, 1'b0, 1'b1, 16'sh0000},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'shFFFF, 1'b1, 1'b1, 16'shFFFF},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh0001, 1'b0, 1'b1, 16'sh0001},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh5A5A, 1'b1, 1'b1, 16'sh5A5A},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'shA5A5, 1'b0, 1'b1, 16'shA5A5},
		// quarter-turn step lands on quadrant edges, full mu, one tap
		'{ROW_WRITE, lsrc_pkg::CFG_PHASE_STEP, 32'h4000_0000, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_WRITE, lsrc_pkg::CFG_STEP_SIZE, 32'h0000_FFFF, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_WRITE, lsrc_pkg::CFG_TAP_COUNT, 32'd1, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh8000, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh8000, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh3039, 1'b1, 1'b0, 16'sh0},
		'{ROW_WRITE, lsrc_pkg::CFG_TAP_COUNT, 32'd0, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh8000, 1'b1, 1'b1, 16'sh8000},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF},
		// tap count above the maximum, phase wraps on every sample
		'{ROW_WRITE, lsrc_pkg::CFG_TAP_COUNT, 32'd63, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_WRITE, lsrc_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh8000, 1'b1, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh0000, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh4E20, 1'b0, 1'b0, 16'sh0},
		'{ROW_WRITE, CfgUnmapped, 32'hFFFF_FFFF, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_WRITE, lsrc_pkg::CFG_TAP_COUNT, 32'd32, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_WRITE, lsrc_pkg::CFG_PHASE_STEP, 32'h0147_AE14, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_WRITE, lsrc_pkg::CFG_STEP_SIZE, 32'd1, 16'sh0, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh1234, 1'b0, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'shEDCC, 1'b1, 1'b0, 16'sh0},
		'{ROW_SAMPLE, lsrc_pkg::CFG_PHASE_STEP, 32'd0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0}
	};

	logic clk;
	logic arst_n;

	lsrc_in_if in_ch();
	lsrc_out_if out_ch();
	lsrc_cfg_if cfg_ch();

	lms_sine_reference_canceller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.results(out_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	logic [lsrc_pkg::PhaseW-1:0] tone_phase;
	logic [lsrc_pkg::PhaseW-1:0] ph_step;
	longint mu_val;
	int taps_reg;
	longint coef [NumTaps];
	longint qsine [QsineLen];

	result_t cleaned_q [$];
	int mismatches;
	int idle_cycles;
	bit gaps_on;
	bit hold_off_req;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Taylor series in Q30 up to x^13, rounded to Q1.15
	function automatic longint qsine_value(input longint unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (i * HalfPiQ30Val) / 64'(QsineLen - 1);
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n < 13; n += 2) begin
			term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
			if (((n + 1) / 2) % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		sum = (sum + 64'sd16384) >>> 15;
		return clip(sum, 0, 32767);
	endfunction

	// mirror quadrants 1 and 3, negate quadrants 2 and 3
	function automatic longint ref_sine(input logic [lsrc_pkg::PhaseW-1:0] p);
		longint unsigned f;
		longint unsigned idx;
		f = {34'd0, p[29:0]};
		if (p[30])
			f = (64'd1 << 30) - f;
		idx = (f * 64'(QsineLen - 1)) >> 30;
		if (idx > 64'(QsineLen - 1))
			idx = 64'(QsineLen - 1);
		return p[31] ? -qsine[idx] : qsine[idx];
	endfunction

	// error for one sample, then adapt the taps in use and advance the phase
	function automatic logic signed [lsrc_pkg::SampleW-1:0] cancel_tone(
			input logic signed [lsrc_pkg::SampleW-1:0] s);
		longint refs [NumTaps];
		longint acc;
		longint e;
		longint d;
		int n;
		logic [lsrc_pkg::PhaseW-1:0] p;
		acc = 0;
		n = (taps_reg > NumTaps) ? NumTaps : taps_reg;
		for (int k = 0; k < n; k++) begin
			p = tone_phase - 32'(k) * ph_step;
			refs[k] = ref_sine(p);
			acc += coef[k] * refs[k];
		end
		e = (longint'(s) * 64'sd1048576 - acc + 64'sd524288) >>> 20;
		e = clip(e, -32768, 32767);
		for (int k = 0; k < n; k++) begin
			d = (mu_val * e * refs[k] + 64'sd16777216) >>> 25;
			coef[k] = clip(coef[k] + d, CoefMin, CoefMax);
		end
		tone_phase = tone_phase + ph_step;
		return 16'(e);
	endfunction

	// leaves valid high so that writes can follow back to back
	task automatic write_reg(input logic [lsrc_pkg::CfgIdxW-1:0] idx,
			input logic [lsrc_pkg::CfgDataW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			lsrc_pkg::CFG_PHASE_STEP: ph_step = val;
			lsrc_pkg::CFG_STEP_SIZE: mu_val = longint'(val[lsrc_pkg::StepW-1:0]);
			lsrc_pkg::CFG_TAP_COUNT: taps_reg = int'(val[lsrc_pkg::TapCntW-1:0]);
			default: ;
		endcase
	endtask

	task automatic push_sample(input logic signed [lsrc_pkg::SampleW-1:0] s, input logic lst,
			input bit known, input logic signed [lsrc_pkg::SampleW-1:0] typed);
		result_t r;
		logic signed [lsrc_pkg::SampleW-1:0] predicted;
		if (gaps_on && $urandom_range(99) < IdlePct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= s;
		in_ch.last_in_block <= lst;
		do @(posedge clk); while (!in_ch.ready);
		predicted = cancel_tone(s);
		r.err = known ? typed : predicted;
		r.last = lst;
		cleaned_q.push_back(r);
	endtask

	// drain every result, then let the update pass finish
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (cleaned_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ch.ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_ch.ready <= !gaps_on || ($urandom_range(99) >= IdlePct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		bit moved;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (cleaned_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, error_out %0d last_out %0b",
						$time, out_ch.error_out, out_ch.last_out);
				end else begin
					want = cleaned_q.pop_front();
					if (out_ch.error_out !== want.err) begin
						mismatches++;
						$display("%0t: error_out expected %0d actual %0d",
							$time, want.err, out_ch.error_out);
					end
					if (out_ch.last_out !== want.last) begin
						mismatches++;
						$display("%0t: last_out expected %0b actual %0b",
							$time, want.last, out_ch.last_out);
					end
				end
			end
			moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready);
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int phase_no;
		int count;
		int taps;
		int mode;
		int nz;
		longint amp;
		longint tone_val;
		logic [lsrc_pkg::PhaseW-1:0] tone_ofs;
		logic [lsrc_pkg::CfgDataW-1:0] step_w;
		logic [lsrc_pkg::CfgDataW-1:0] mu_w;
		logic [lsrc_pkg::CfgDataW-1:0] taps_w;
		logic signed [lsrc_pkg::SampleW-1:0] smp;
		bit in_flight;

		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.sample_in <= '0;
		in_ch.last_in_block <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= lsrc_pkg::CFG_PHASE_STEP;
		cfg_ch.data <= '0;
		mismatches = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		hold_off_req = 1'b0;
		in_flight = 1'b0;

		tone_phase = '0;
		ph_step = '0;
		mu_val = 0;
		taps_reg = int'(lsrc_pkg::TapCountReset);
		foreach (coef[k])
			coef[k] = 0;
		for (int i = 0; i < QsineLen; i++)
			qsine[i] = qsine_value(i);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DirLen; r++) begin
			if (DirRows[r].kind == ROW_WRITE) begin
				if (in_flight) begin
					wait_idle();
					in_flight = 1'b0;
				end
				write_reg(DirRows[r].idx, DirRows[r].data);
				if (r + 1 == DirLen || DirRows[r + 1].kind != ROW_WRITE)
					cfg_ch.valid <= 1'b0;
			end else begin
				push_sample(DirRows[r].sample, DirRows[r].last, DirRows[r].known,
					DirRows[r].err);
				in_flight = 1'b1;
			end
		end

		sent = 0;
		phase_no = 0;
		while (sent < RandomItems) begin
			wait_idle();
			case ($urandom_range(9))
				0: taps = 0;
				1: taps = 32;
				2: taps = $urandom_range(33, 63);
				3: taps = $urandom_range(9, 31);
				default: taps = $urandom_range(1, 8);
			endcase
			case ($urandom_range(4))
				0: step_w = '0;
				1: step_w = 32'hFFFF_FFFF;
				2: step_w = $urandom;
				default: step_w = $urandom_range(1, 32'h0800_0000);
			endcase
			case ($urandom_range(4))
				0: mu_w = '0;
				1: mu_w = 32'h0000_FFFF;
				2: mu_w = $urandom;
				default: mu_w = $urandom_range(1, 4000);
			endcase
			// upper bits of the tap count write are don't-care
			taps_w = $urandom;
			taps_w[lsrc_pkg::TapCntW-1:0] = taps[lsrc_pkg::TapCntW-1:0];
			write_reg(lsrc_pkg::CFG_PHASE_STEP, step_w);
			write_reg(lsrc_pkg::CFG_STEP_SIZE, mu_w);
			write_reg(lsrc_pkg::CFG_TAP_COUNT, taps_w);
			if ($urandom_range(3) == 0)
				write_reg(CfgUnmapped, $urandom);
			cfg_ch.valid <= 1'b0;

			gaps_on = (phase_no != 3);
			if (phase_no == 1)
				hold_off_req = 1'b1;
			count = (phase_no == 1 || phase_no == 3) ? 150 : $urandom_range(20, 120);
			amp = $urandom_range(0, 30000);
			tone_ofs = $urandom;

			repeat (count) begin
				mode = $urandom_range(99);
				if (mode < 70) begin
					nz = $urandom_range(0, 2000);
					tone_val = ((amp * ref_sine(tone_phase + tone_ofs)) >>> 15)
						+ longint'($urandom_range(0, 2 * nz)) - nz;
					smp = 16'(clip(tone_val, -32768, 32767));
				end else if (mode < 80) begin
					smp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				end else begin
					smp = 16'($urandom);
				end
				push_sample(smp, ($urandom_range(15) == 0), 1'b0, '0);
				sent++;
			end
			gaps_on = 1'b1;
			phase_no++;
		end

		wait_idle();
		if (mismatches == 0 && cleaned_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
